### hdl/lpra_pkg.sv
`default_nettype none

package lpra_pkg;

   localparam int CHANNEL_COUNT_DEF  = 2;
   localparam int PRIORITY_COUNT_DEF = 8;

   localparam int CMD_W       = 2;
   localparam int CHAN_W      = 1;
   localparam int PRIO_W      = 3;
   localparam int PAT_W       = 3;
   localparam int COLOR_W     = 24;
   localparam int TIME_W      = 32;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 32;

   localparam logic [COLOR_W-1:0] DEFAULT_COLOR = 24'h00FF00;
   localparam logic [PAT_W-1:0]   PAT_OFF       = 3'd0;
   localparam logic [PAT_W-1:0]   PAT_SOLID     = 3'd1;
   localparam logic [PAT_W-1:0]   PAT_MAX_VALID = 3'd5;

   typedef enum logic [CMD_W-1:0] {
      CMD_REQUEST = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_TICK    = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic slot_write;
      logic ms_advance;
      logic scan_apply;
      logic held_load;
      logic held_clear;
      logic out_load;
      logic out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic change;
      logic held_valid;
      logic out_free;
   } dp_sts_type;

   // Codes above rainbow drive the LED off.
   function automatic logic [PAT_W-1:0] drive_code(input logic [PAT_W-1:0] pat);
      return (pat > PAT_MAX_VALID) ? PAT_OFF : pat;
   endfunction

endpackage

`default_nettype wire

### hdl/led_priority_request_arbiter.sv
`default_nettype none

// LED priority request arbiter. Each LED channel keeps one request slot per
// priority (slot 0 wins); a request fills a slot with pattern, color and an
// optional timeout, a release clears it, and a millisecond tick expires old
// slots and emits one transaction for each channel whose winning pattern or
// color changed, with tlast on the final one of that tick. Requests, releases
// and unused commands are taken in the idle state. A tick is accepted in the
// idle state, which advances the millisecond count; the scan then takes one
// step per channel, comparing that channel's expiries in parallel, and the
// flush state pushes out the held final change. A scan step that must push
// out an earlier change, and the flush, wait while the output register still
// holds an untaken transaction. The lowest-priority slot of every channel
// holds solid green after reset, and the block accepts transactions from the
// first cycle after reset.
module led_priority_request_arbiter
   import lpra_pkg::*;
#(
   parameter int CHANNEL_COUNT  = CHANNEL_COUNT_DEF,
   parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [1:0] command, [2] channel, [5:3] priority_req, [8:6] pattern,
   // [32:9] color, [64:33] timeout, [71:65] zero
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [0] led_channel, [3:1] shown_pattern, [27:4] shown_color, [31:28] zero
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int ChanWidth = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam int PrioWidth = $clog2(PRIORITY_COUNT);

   dp_cmd_type           cmd;
   dp_sts_type           sts;
   logic [ChanWidth-1:0] chan;

   lpra_ctrl #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .ChanWidth     (ChanWidth)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tdata[1:0]),
      .sts         (sts),
      .cmd         (cmd),
      .chan        (chan)
   );

   lpra_dp #(
      .CHANNEL_COUNT  (CHANNEL_COUNT),
      .PRIORITY_COUNT (PRIORITY_COUNT),
      .ChanWidth      (ChanWidth),
      .PrioWidth      (PrioWidth)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .chan       (chan),
      .sts        (sts)
   );

endmodule

`default_nettype wire

### hdl/lpra_ctrl.sv
`default_nettype none

module lpra_ctrl
   import lpra_pkg::*;
#(
   parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
   parameter int ChanWidth     = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [CMD_W-1:0]     req_command,
   input  wire dp_sts_type           sts,
   output dp_cmd_type                cmd,
   output logic [ChanWidth-1:0]      chan
);

   state_type             state_ff, state_in;
   logic [ChanWidth-1:0]  chan_ff, chan_in;
   logic                  stall;
   logic                  last_chan;

   assign stall     = sts.change && sts.held_valid && !sts.out_free;
   assign last_chan = (chan_ff == ChanWidth'(CHANNEL_COUNT - 1));
   assign chan      = chan_ff;

   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      case (state_ff)
         ST_IDLE: begin
            chan_in = '0;
            if (req_tvalid && command_type'(req_command) == CMD_TICK) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (last_chan) begin
                  state_in = ST_FLUSH;
               end else begin
                  chan_in = chan_ff + ChanWidth'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.held_valid || sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               case (command_type'(req_command))
                  CMD_REQUEST, CMD_RELEASE: cmd.slot_write = 1'b1;
                  CMD_TICK:                 cmd.ms_advance = 1'b1;
                  default:                  cmd = '0;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan_apply = !stall;
            cmd.held_load  = sts.change && !stall;
            // A new change pushes the previous one out as a non-final transaction.
            cmd.out_load   = sts.change && sts.held_valid && !stall;
         end
         ST_FLUSH: begin
            if (sts.held_valid && sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_last   = 1'b1;
               cmd.held_clear = 1'b1;
            end
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !sts.held_valid)
      else $error("held result left over in idle");

   a_stall_holds_chan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && stall) |=> (state_ff == ST_SCAN && $stable(chan_ff)))
      else $error("scan advanced while output blocked");

endmodule

`default_nettype wire

### hdl/lpra_dp.sv
`default_nettype none

module lpra_dp
   import lpra_pkg::*;
#(
   parameter int CHANNEL_COUNT  = CHANNEL_COUNT_DEF,
   parameter int PRIORITY_COUNT = PRIORITY_COUNT_DEF,
   parameter int ChanWidth      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1,
   parameter int PrioWidth      = $clog2(PRIORITY_COUNT)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tlast,
   input  wire dp_cmd_type             cmd,
   input  wire logic [ChanWidth-1:0]   chan,
   output dp_sts_type                  sts
);

   // Input fields
   logic [CMD_W-1:0]   f_command;
   logic [CHAN_W-1:0]  f_channel;
   logic [PRIO_W-1:0]  f_priority;
   logic [PAT_W-1:0]   f_pattern;
   logic [COLOR_W-1:0] f_color;
   logic [TIME_W-1:0]  f_timeout;

   assign f_command  = req_tdata[1:0];
   assign f_channel  = req_tdata[2];
   assign f_priority = req_tdata[5:3];
   assign f_pattern  = req_tdata[8:6];
   assign f_color    = req_tdata[32:9];
   assign f_timeout  = req_tdata[64:33];

   // Slot table
   logic [PRIORITY_COUNT-1:0] active_ff  [CHANNEL_COUNT];
   logic [PAT_W-1:0]          pattern_ff [CHANNEL_COUNT][PRIORITY_COUNT];
   logic [COLOR_W-1:0]        color_ff   [CHANNEL_COUNT][PRIORITY_COUNT];
   logic [TIME_W-1:0]         expiry_ff  [CHANNEL_COUNT][PRIORITY_COUNT];

   logic [PAT_W-1:0]   shown_pattern_ff [CHANNEL_COUNT];
   logic [COLOR_W-1:0] shown_color_ff   [CHANNEL_COUNT];
   logic [TIME_W-1:0]  ms_ff;

   logic                 held_valid_ff;
   logic [ChanWidth-1:0] held_chan_ff;
   logic [PAT_W-1:0]     held_pattern_ff;
   logic [COLOR_W-1:0]   held_color_ff;

   logic                 out_valid_ff;
   logic                 out_chan_ff;
   logic [PAT_W-1:0]     out_pattern_ff;
   logic [COLOR_W-1:0]   out_color_ff;
   logic                 out_last_ff;

   logic                 in_range;
   logic [ChanWidth-1:0] wr_chan;
   logic [PrioWidth-1:0] wr_prio;
   logic [TIME_W-1:0]    new_expiry;

   logic [PRIORITY_COUNT-1:0] live_row;
   logic                      found;
   logic [PrioWidth-1:0]      win;
   logic [PAT_W-1:0]          win_pattern;
   logic [COLOR_W-1:0]        win_color;
   logic                      change;

   assign in_range   = (int'(f_channel) < CHANNEL_COUNT) && (int'(f_priority) < PRIORITY_COUNT);
   assign wr_chan    = ChanWidth'(f_channel);
   assign wr_prio    = PrioWidth'(f_priority);
   assign new_expiry = (f_timeout != '0) ? (ms_ff + f_timeout) : '0;

   // Drop expired slots of the scanned channel, then pick the highest-priority live one.
   always_comb begin
      for (int p = 0; p < PRIORITY_COUNT; p++) begin
         live_row[p] = active_ff[chan][p] &&
                       !((expiry_ff[chan][p] != '0) && (ms_ff >= expiry_ff[chan][p]));
      end
      found = 1'b0;
      win   = '0;
      for (int p = PRIORITY_COUNT - 1; p >= 0; p--) begin
         if (live_row[p]) begin
            found = 1'b1;
            win   = PrioWidth'(p);
         end
      end
   end

   assign win_pattern = pattern_ff[chan][win];
   assign win_color   = color_ff[chan][win];
   assign change      = found && ((win_pattern != shown_pattern_ff[chan]) ||
                                  (win_color != shown_color_ff[chan]));

   assign sts.change     = change;
   assign sts.held_valid = held_valid_ff;
   assign sts.out_free   = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNEL_COUNT; c++) begin
            for (int p = 0; p < PRIORITY_COUNT; p++) begin
               active_ff[c][p]  <= (p == PRIORITY_COUNT - 1);
               pattern_ff[c][p] <= (p == PRIORITY_COUNT - 1) ? PAT_SOLID : PAT_OFF;
               color_ff[c][p]   <= (p == PRIORITY_COUNT - 1) ? DEFAULT_COLOR : '0;
               expiry_ff[c][p]  <= '0;
            end
            shown_pattern_ff[c] <= PAT_OFF;
            shown_color_ff[c]   <= '0;
         end
         ms_ff <= '0;
      end else begin
         if (cmd.slot_write && in_range) begin
            if (command_type'(f_command) == CMD_REQUEST) begin
               active_ff[wr_chan][wr_prio]  <= 1'b1;
               pattern_ff[wr_chan][wr_prio] <= f_pattern;
               color_ff[wr_chan][wr_prio]   <= f_color;
               expiry_ff[wr_chan][wr_prio]  <= new_expiry;
            end else begin
               active_ff[wr_chan][wr_prio]  <= 1'b0;
            end
         end
         if (cmd.ms_advance) begin
            ms_ff <= ms_ff + TIME_W'(1);
         end
         if (cmd.scan_apply) begin
            active_ff[chan] <= live_row;
            if (change) begin
               shown_pattern_ff[chan] <= win_pattern;
               shown_color_ff[chan]   <= win_color;
            end
         end
      end
   end

   // Pending change: held back until we know whether another one follows.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
      end else if (cmd.held_load) begin
         held_valid_ff <= 1'b1;
      end else if (cmd.held_clear) begin
         held_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.held_load) begin
         held_chan_ff    <= chan;
         held_pattern_ff <= win_pattern;
         held_color_ff   <= win_color;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_chan_ff    <= held_chan_ff[0];
         out_pattern_ff <= drive_code(held_pattern_ff);
         out_color_ff   <= held_color_ff;
         out_last_ff    <= cmd.out_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_color_ff, out_pattern_ff, out_chan_ff};
   assign rsp_tlast  = out_last_ff;

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten before transaction completed");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("waiting transaction changed before it was taken");

endmodule

`default_nettype wire

### test/tb_led_priority_request_arbiter.sv
`timescale 1ns / 1ps

module tb_led_priority_request_arbiter;
   import lpra_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1500;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      logic [PAT_W-1:0]   pat;
      logic [COLOR_W-1:0] rgb;
      logic               last;
   } led_change_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [1:0] command, [2] channel, [5:3] priority_req, [8:6] pattern,
   // [32:9] color, [64:33] timeout, [71:65] zero
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] led_channel, [3:1] shown_pattern, [27:4] shown_color, [31:28] zero
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   // Mirror of the request slots and of what each channel shows
   logic               slot_on       [CHANNEL_COUNT_DEF][PRIORITY_COUNT_DEF];
   logic [PAT_W-1:0]   slot_pat      [CHANNEL_COUNT_DEF][PRIORITY_COUNT_DEF];
   logic [COLOR_W-1:0] slot_rgb      [CHANNEL_COUNT_DEF][PRIORITY_COUNT_DEF];
   logic [TIME_W-1:0]  slot_deadline [CHANNEL_COUNT_DEF][PRIORITY_COUNT_DEF];
   logic [PAT_W-1:0]   shown_pat     [CHANNEL_COUNT_DEF];
   logic [COLOR_W-1:0] shown_rgb     [CHANNEL_COUNT_DEF];
   logic [TIME_W-1:0]  ms_now;

   led_change_type pending_changes [$];
   int             mismatches = 0;
   logic           tx_quiet = 1'b0;
   logic           rsp_quiet = 1'b0;
   int             hold_requests = 0;

   led_priority_request_arbiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

   function automatic void clear_led_slots();
      for (int c = 0; c < CHANNEL_COUNT_DEF; c++) begin
         for (int p = 0; p < PRIORITY_COUNT_DEF; p++) begin
            slot_on[c][p]       = (p == PRIORITY_COUNT_DEF - 1);
            slot_pat[c][p]      = (p == PRIORITY_COUNT_DEF - 1) ? PAT_SOLID : PAT_OFF;
            slot_rgb[c][p]      = (p == PRIORITY_COUNT_DEF - 1) ? DEFAULT_COLOR : '0;
            slot_deadline[c][p] = '0;
         end
         shown_pat[c] = PAT_OFF;
         shown_rgb[c] = '0;
      end
      ms_now = '0;
   endfunction

   // Update the slot mirror for one accepted transaction and queue the changes a tick shows
   function automatic void apply_led_command(input logic [CMD_W-1:0] cmd,
                                             input logic [CHAN_W-1:0] ch,
                                             input logic [PRIO_W-1:0] prio,
                                             input logic [PAT_W-1:0] pat,
                                             input logic [COLOR_W-1:0] rgb,
                                             input logic [TIME_W-1:0] tmo);
      led_change_type found [CHANNEL_COUNT_DEF];
      int             n;
      int             win;
      n = 0;
      if (cmd == CMD_REQUEST) begin
         slot_on[ch][prio]       = 1'b1;
         slot_pat[ch][prio]      = pat;
         slot_rgb[ch][prio]      = rgb;
         slot_deadline[ch][prio] = (tmo != '0) ? ms_now + tmo : '0;
      end else if (cmd == CMD_RELEASE) begin
         slot_on[ch][prio] = 1'b0;
      end else if (cmd == CMD_TICK) begin
         ms_now = ms_now + 1;
         for (int c = 0; c < CHANNEL_COUNT_DEF; c++)
            for (int p = 0; p < PRIORITY_COUNT_DEF; p++)
               if (slot_on[c][p] && slot_deadline[c][p] != '0 &&
                   ms_now >= slot_deadline[c][p])
                  slot_on[c][p] = 1'b0;
         for (int c = 0; c < CHANNEL_COUNT_DEF; c++) begin
            win = -1;
            for (int p = PRIORITY_COUNT_DEF - 1; p >= 0; p--)
               if (slot_on[c][p])
                  win = p;
            if (win >= 0 && (shown_pat[c] != slot_pat[c][win] ||
                             shown_rgb[c] != slot_rgb[c][win])) begin
               shown_pat[c]    = slot_pat[c][win];
               shown_rgb[c]    = slot_rgb[c][win];
               found[n].chan   = CHAN_W'(c);
               // codes past rainbow are kept as given but drive the LED dark
               found[n].pat    = (shown_pat[c] > PAT_MAX_VALID) ? PAT_OFF : shown_pat[c];
               found[n].rgb    = shown_rgb[c];
               found[n].last   = 1'b0;
               n++;
            end
         end
         if (n > 0)
            found[n-1].last = 1'b1;
         for (int i = 0; i < n; i++)
            pending_changes.push_back(found[i]);
      end
   endfunction

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [CHAN_W-1:0] ch,
                            input logic [PRIO_W-1:0] prio, input logic [PAT_W-1:0] pat,
                            input logic [COLOR_W-1:0] rgb, input logic [TIME_W-1:0] tmo);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, tmo, rgb, pat, prio, ch, cmd};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      apply_led_command(cmd, ch, prio, pat, rgb, tmo);
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, '0, '0, '0, '0, '0);
   endtask

   // Receiver: random stall per transaction, plus one long hold-off on request
   initial begin : drain_rsp
      int stall;
      int holds_taken;
      holds_taken = 0;
      forever begin
         if (holds_taken != hold_requests) begin
            holds_taken++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = rsp_quiet ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      led_change_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_changes.size() == 0) begin
            $display("%0t: unexpected transaction expected none actual 0x%0h last %0b",
                     $time, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_changes.pop_front();
            check_field("led_channel", 32'(want.chan), 32'(rsp_tdata[0]));
            check_field("shown_pattern", 32'(want.pat), 32'(rsp_tdata[3:1]));
            check_field("shown_color", 32'(want.rgb), 32'(rsp_tdata[27:4]));
            check_field("pad bits", 32'd0, 32'(rsp_tdata[31:28]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Both default slots show solid green on the first tick
   task automatic test_reset_defaults();
      send_tick();
   endtask

   task automatic test_directed_cases();
      // pattern code 7 then 6: stored as given, both drive off
      send_item(CMD_REQUEST, 1'b0, 3'd0, 3'd7, 24'hFFFFFF, 32'd0);
      send_tick();
      send_item(CMD_REQUEST, 1'b0, 3'd0, 3'd6, 24'hFFFFFF, 32'd0);
      send_tick();
      // all-ones timeout lands behind the counter, timeout one ends at the next tick
      send_item(CMD_REQUEST, 1'b1, 3'd3, 3'd5, 24'h000000, 32'hFFFFFFFF);
      send_item(CMD_REQUEST, 1'b1, 3'd2, 3'd4, 24'h123456, 32'd1);
      send_tick();
      send_item(CMD_UNUSED, 1'b1, 3'd7, 3'd7, 24'hFFFFFF, 32'hFFFFFFFF);
      // expiry wraps to zero, so the slot never expires
      send_item(CMD_REQUEST, 1'b1, 3'd0, 3'd0, 24'h000000, 32'd0 - ms_now);
      send_tick();
      // empty channel keeps its shown state
      send_item(CMD_RELEASE, 1'b1, 3'd0, 3'd0, 24'h0, 32'd0);
      send_item(CMD_RELEASE, 1'b1, 3'd7, 3'd0, 24'h0, 32'd0);
      send_tick();
      send_item(CMD_REQUEST, 1'b1, 3'd7, 3'd3, 24'hAAAAAA, 32'd2);
      send_tick();
      send_tick();
      send_item(CMD_RELEASE, 1'b0, 3'd0, 3'd0, 24'h0, 32'd0);
      send_tick();
      send_item(CMD_REQUEST, 1'b0, 3'd1, 3'd2, 24'h555555, 32'd3);
      send_tick();
      send_tick();
      send_tick();
      send_item(CMD_REQUEST, 1'b1, 3'd7, 3'd1, DEFAULT_COLOR, 32'd0);
      send_tick();
   endtask

   // Stall the output for a long stretch while ticks keep coming
   task automatic test_output_stall();
      tx_quiet = 1'b1;
      hold_requests++;
      for (int i = 0; i < 20; i++) begin
         send_item(CMD_REQUEST, i[0], 3'd0, PAT_W'($urandom_range(0, 7)),
                   COLOR_W'($urandom), 32'd0);
         send_tick();
      end
      tx_quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      logic [CMD_W-1:0]   cmd;
      logic [COLOR_W-1:0] rgb;
      logic [TIME_W-1:0]  tmo;
      int                 pick;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 64 == 0) begin
            tx_quiet  = ($urandom_range(0, 3) == 0);
            rsp_quiet = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 19);
         if (pick < 7)
            cmd = CMD_TICK;
         else if (pick < 15)
            cmd = CMD_REQUEST;
         else if (pick < 19)
            cmd = CMD_RELEASE;
         else
            cmd = CMD_UNUSED;
         // a small palette makes repeated colors, hence ticks with no change
         rgb = $urandom_range(0, 1) ? COLOR_W'($urandom) : COLOR_W'($urandom_range(0, 3));
         case ($urandom_range(0, 9))
            0, 1, 2: tmo = '0;
            8:       tmo = $urandom;
            9:       tmo = 32'hFFFFFFFF - $urandom_range(0, 3);
            default: tmo = $urandom_range(1, 20);
         endcase
         send_item(cmd, CHAN_W'($urandom_range(0, 1)), PRIO_W'($urandom_range(0, 7)),
                   PAT_W'($urandom_range(0, 7)), rgb, tmo);
      end
      tx_quiet  = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   initial begin
      clear_led_slots();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_output_stall();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (pending_changes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
